// ===== rtl/wmsk_pkg.sv =====
// Shared types, constants and register codes for the weighted 2x map shrink.
`default_nettype none
package wmsk_pkg;

  localparam int VALUE_BITS       = 16;
  localparam int WEIGHT_BITS      = 16;
  localparam int MAX_IN_WIDTH_DEF = 2048;

  // configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam int GEO_IN_BITS  = 12;
  localparam int GEO_OUT_BITS = 11;

  localparam logic [CFG_IW-1:0] CFG_IN_WIDTH   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_IN_HEIGHT  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_WEIGHT_PR  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_SCALE      = 3'd5;

  localparam logic [WEIGHT_BITS-1:0] ONE_WEIGHT = 16'd256;

  // accumulator widths (taps 1,2,1 per axis, 16-bit weights)
  localparam int S1W  = 20;
  localparam int S2W  = 22;
  localparam int SVW  = 36;
  // shared divider
  localparam int NUMW = 52;
  localparam int DENW = 28;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] pixel_value;
    logic [WEIGHT_BITS-1:0]       pixel_weight;
  } wmsk_in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] out_value;
    logic [WEIGHT_BITS-1:0]       out_weight;
    logic                         out_bad;
    logic                         run_last;
    logic                         frame_last;
  } wmsk_out_t;

  typedef struct packed {
    logic take;
    logic wv;
    logic row;
    logic job2;
    logic col;
    logic ema_clr;
    logic emb;
    logic mul_v;
    logic mul_w;
    logic div_v;
    logic div_w;
    logic fin_v;
    logic fin_w;
    logic stage;
    logic push_last;
  } wmsk_cmd_t;

  typedef struct packed {
    logic job;
    logic job2;
    logic xb_ok;
    logic em_a;
    logic em_b;
    logic div_busy;
    logic stage_vld;
    logic out_free;
  } wmsk_sts_t;

endpackage
`default_nettype wire

// ===== rtl/wmsk_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module wmsk_div #(
  parameter int NW = wmsk_pkg::NUMW,
  parameter int DW = wmsk_pkg::DENW
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               busy,
  output logic [NW-1:0]      quo,
  output logic [DW-1:0]      rem
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;
  logic          qbit;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

// ===== rtl/wmsk_datapath.sv =====
// Datapath: config registers, position, row and column sums, multiplier, divider, output.
`default_nettype none
module wmsk_datapath #(
  parameter int MAX_IN_WIDTH = wmsk_pkg::MAX_IN_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire wmsk_pkg::wmsk_in_t          in_data,
  input  wire logic                        cfg_we,
  input  wire logic [wmsk_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [wmsk_pkg::CFG_DW-1:0] cfg_data,
  input  wire wmsk_pkg::wmsk_cmd_t         cmd,
  output wmsk_pkg::wmsk_sts_t              sts,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output wmsk_pkg::wmsk_out_t              out_data
);
  import wmsk_pkg::*;

  localparam int NXW   = $clog2(MAX_IN_WIDTH + 1);
  localparam int GW    = (NXW > GEO_IN_BITS) ? NXW : GEO_IN_BITS;
  localparam int DEPTH = MAX_IN_WIDTH / 2 + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = S1W + S2W + SVW;
  localparam int QW    = NUMW + 1;
  localparam int VMAX  = 2 ** (VALUE_BITS - 1) - 1;
  localparam int WMAX  = 2 ** WEIGHT_BITS - 1;

  // configuration
  logic [GEO_IN_BITS-1:0]  in_width_r, in_height_r;
  logic [GEO_OUT_BITS-1:0] out_width_r, out_height_r;
  logic                    wp_r;
  logic signed [15:0]      scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r   <= 12'd2048;
      in_height_r  <= 12'd2048;
      out_width_r  <= 11'd1024;
      out_height_r <= 11'd1024;
      wp_r         <= 1'b1;
      scale_r      <= 16'sd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IN_WIDTH:   in_width_r   <= cfg_data[GEO_IN_BITS-1:0];
        CFG_IN_HEIGHT:  in_height_r  <= cfg_data[GEO_IN_BITS-1:0];
        CFG_OUT_WIDTH:  out_width_r  <= cfg_data[GEO_OUT_BITS-1:0];
        CFG_OUT_HEIGHT: out_height_r <= cfg_data[GEO_OUT_BITS-1:0];
        CFG_WEIGHT_PR:  wp_r         <= cfg_data[0];
        CFG_SCALE:      scale_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [GW-1:0]           iw_g, nx_g, ow_g, lim_g, ew_g;
  logic [NXW-1:0]          nx, ew, lim_w;
  logic [GEO_IN_BITS-1:0]  ny, eh, lim_h, oh_g;
  logic [GEO_OUT_BITS-1:0] ow, oh;

  always_comb begin
    iw_g = GW'(in_width_r);
    if (iw_g == '0)                     nx_g = GW'(1);
    else if (iw_g > GW'(MAX_IN_WIDTH))  nx_g = GW'(MAX_IN_WIDTH);
    else                                nx_g = iw_g;
    nx    = nx_g[NXW-1:0];
    ny    = (in_height_r == '0) ? GEO_IN_BITS'(1) : in_height_r;
    ow    = (out_width_r == '0) ? GEO_OUT_BITS'(1) : out_width_r;
    oh    = (out_height_r == '0) ? GEO_OUT_BITS'(1) : out_height_r;
    lim_w = (nx >> 1) + 1'b1;
    ow_g  = GW'(ow);
    lim_g = GW'(lim_w);
    ew_g  = (ow_g < lim_g) ? ow_g : lim_g;
    ew    = ew_g[NXW-1:0];
    lim_h = (ny >> 1) + 1'b1;
    oh_g  = GEO_IN_BITS'(oh);
    eh    = (oh_g < lim_h) ? oh_g : lim_h;
  end

  // raster position
  logic [NXW-1:0]         x_r, xcur_r, xc, xn;
  logic [GEO_IN_BITS-1:0] y_r, ycur_r, yc, yn;

  always_comb begin
    xc = x_r;
    yc = y_r;
    if (x_r >= nx) begin
      xc = '0;
      yc = y_r + 1'b1;
    end
    if (yc >= ny) yc = '0;
    xn = xc + 1'b1;
    yn = yc;
    if (xn >= nx) begin
      xn = '0;
      yn = yc + 1'b1;
      if (yn >= ny) yn = '0;
    end
  end

  logic [WEIGHT_BITS-1:0]       w1_r;
  logic signed [VALUE_BITS-1:0] v_r;
  logic signed [32:0]           wv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (cmd.take) begin
      x_r <= xn;
      y_r <= yn;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      xcur_r <= xc;
      ycur_r <= yc;
      w1_r   <= wp_r ? in_data.pixel_weight : ONE_WEIGHT;
      v_r    <= in_data.pixel_value;
    end
    if (cmd.wv) wv_r <= $signed({1'b0, w1_r}) * v_r;
  end

  // horizontal pass
  logic [S1W-1:0]        w_1, rw_r, h1_r;
  logic [S2W-1:0]        w_2, rs_r, h2_r;
  logic signed [SVW-1:0] w_v, rv_r, hv_r;
  logic [NXW-1:0]        xb_r;
  logic                  job_r, job2_r;
  logic                  x_first, x_last;

  always_comb begin
    w_1     = S1W'(w1_r);
    w_2     = S2W'(w1_r);
    w_v     = SVW'(wv_r);
    x_first = (xcur_r == '0);
    x_last  = (xcur_r == nx - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rw_r   <= '0;
      rs_r   <= '0;
      rv_r   <= '0;
      job_r  <= 1'b0;
      job2_r <= 1'b0;
    end else if (cmd.row) begin
      if (!xcur_r[0]) begin
        rw_r   <= (x_first ? '0 : rw_r) + (w_1 << 1);
        rs_r   <= (x_first ? '0 : rs_r) + (w_2 << 2);
        rv_r   <= (x_first ? '0 : rv_r) + (w_v <<< 1);
        job_r  <= x_last;
        job2_r <= 1'b0;
      end else begin
        rw_r   <= w_1;
        rs_r   <= w_2;
        rv_r   <= w_v;
        job_r  <= 1'b1;
        job2_r <= x_last;
      end
    end else if (cmd.job2) begin
      job2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row) begin
      xb_r <= xcur_r >> 1;
      if (!xcur_r[0]) begin
        h1_r <= (x_first ? '0 : rw_r) + (w_1 << 1);
        h2_r <= (x_first ? '0 : rs_r) + (w_2 << 2);
        hv_r <= (x_first ? '0 : rv_r) + (w_v <<< 1);
      end else begin
        h1_r <= rw_r + w_1;
        h2_r <= rs_r + w_2;
        hv_r <= rv_r + w_v;
      end
    end else if (cmd.job2) begin
      xb_r <= xb_r + 1'b1;
      h1_r <= w_1;
      h2_r <= w_2;
      hv_r <= w_v;
    end
  end

  // column store
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_r, wdata;

  always_ff @(posedge clk) begin
    if (cmd.col) mem[xb_r[AW-1:0]] <= wdata;
    rd_r <= mem[xb_r[AW-1:0]];
  end

  // vertical pass
  logic [S1W-1:0]         c1, n1;
  logic [S2W-1:0]         c2, n2;
  logic signed [SVW-1:0]  cv, nv;
  logic [GEO_IN_BITS-1:0] yb;
  logic                   last_row, xb_last, fl_a, fl_b, ema_nxt, emb_nxt;

  always_comb begin
    {c1, c2, cv} = rd_r;
    yb       = ycur_r >> 1;
    last_row = (ycur_r == ny - 1'b1);
    xb_last  = (xb_r == ew - 1'b1);
    fl_a     = (yb == eh - 1'b1) && xb_last;
    fl_b     = (yb + 1'b1 == eh - 1'b1) && xb_last;
    if (!ycur_r[0]) begin
      n1      = ((ycur_r == '0) ? '0 : c1) + (h1_r << 1);
      n2      = ((ycur_r == '0) ? '0 : c2) + (h2_r << 2);
      nv      = ((ycur_r == '0) ? '0 : cv) + (hv_r <<< 1);
      wdata   = {n1, n2, nv};
      ema_nxt = last_row && (yb < eh);
      emb_nxt = 1'b0;
    end else begin
      n1      = c1 + h1_r;
      n2      = c2 + h2_r;
      nv      = cv + hv_r;
      wdata   = {h1_r, h2_r, hv_r};
      ema_nxt = (yb < eh);
      emb_nxt = last_row && (yb + 1'b1 < eh);
    end
  end

  logic [S1W-1:0]        e1_r;
  logic [S2W-1:0]        e2_r;
  logic signed [SVW-1:0] ev_r;
  logic                  efl_r, flb_r, ema_r, emb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ema_r <= 1'b0;
      emb_r <= 1'b0;
    end else if (cmd.col) begin
      ema_r <= ema_nxt;
      emb_r <= emb_nxt;
    end else if (cmd.ema_clr) begin
      ema_r <= 1'b0;
    end else if (cmd.emb) begin
      emb_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col) begin
      e1_r  <= n1;
      e2_r  <= n2;
      ev_r  <= nv;
      efl_r <= fl_a;
      flb_r <= fl_b;
    end else if (cmd.emb) begin
      e1_r  <= h1_r;
      e2_r  <= h2_r;
      ev_r  <= hv_r;
      efl_r <= flb_r;
    end
  end

  // shared multiplier and divider
  logic [SVW-1:0]  ma, mag_ev;
  logic [S1W-1:0]  mb;
  logic [15:0]     mag_sc;
  logic [SVW+S1W-1:0] prod_r;
  logic            div_busy;
  logic [NUMW-1:0] quo;
  logic [DENW-1:0] rem, den;

  always_comb begin
    mag_ev = ev_r[SVW-1] ? SVW'(-ev_r) : SVW'(ev_r);
    mag_sc = scale_r[15] ? 16'(-scale_r) : 16'(scale_r);
    ma     = cmd.mul_w ? SVW'(e1_r) : mag_ev;
    mb     = cmd.mul_w ? e1_r : S1W'(mag_sc);
    den    = (cmd.div_v || cmd.fin_v) ? {e1_r, 8'b0} : DENW'(e2_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_v || cmd.mul_w) prod_r <= ma * mb;
  end

  wmsk_div #(.NW(NUMW), .DW(DENW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_v || cmd.div_w),
    .dividend (prod_r[NUMW-1:0]),
    .divisor  (den),
    .busy     (div_busy),
    .quo      (quo),
    .rem      (rem)
  );

  // rounding and saturation
  logic [QW-1:0]          q;
  logic                   neg, zero_v, zero_w;
  logic [VALUE_BITS-1:0]  qlo, val_nxt;
  logic [WEIGHT_BITS-1:0] wgt_nxt;

  always_comb begin
    q      = {1'b0, quo} + QW'({rem, 1'b0} >= {1'b0, den});
    neg    = ev_r[SVW-1] ^ scale_r[15];
    zero_v = (e1_r == '0) || (e2_r == '0) || (ev_r == '0) || (scale_r == '0);
    zero_w = (e1_r == '0) || (e2_r == '0) || !wp_r;
    qlo    = q[VALUE_BITS-1:0];
    if (zero_v)                         val_nxt = '0;
    else if (neg && q > QW'(VMAX + 1))  val_nxt = {1'b1, {(VALUE_BITS-1){1'b0}}};
    else if (neg)                       val_nxt = ~qlo + 1'b1;
    else if (q > QW'(VMAX))             val_nxt = {1'b0, {(VALUE_BITS-1){1'b1}}};
    else                                val_nxt = qlo;
    if (zero_w)                 wgt_nxt = '0;
    else if (q > QW'(WMAX))     wgt_nxt = '1;
    else                        wgt_nxt = q[WEIGHT_BITS-1:0];
  end

  logic [VALUE_BITS-1:0] val_r;
  wmsk_out_t             stg_r, out_r, push_data;
  logic                  stg_vld_r, out_valid_r, push;

  always_ff @(posedge clk) begin
    if (cmd.fin_v) val_r <= val_nxt;
    if (cmd.fin_w) begin
      stg_r <= '{out_value: val_r, out_weight: wgt_nxt, out_bad: (e1_r == '0),
                 run_last: 1'b0, frame_last: efl_r};
    end
  end

  // staged result goes out once the next one exists or the item is done
  assign push = (cmd.stage && stg_vld_r) || cmd.push_last;

  always_comb begin
    push_data          = stg_r;
    push_data.run_last = cmd.push_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.stage)          stg_vld_r <= 1'b1;
      else if (cmd.push_last) stg_vld_r <= 1'b0;
      if (push)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) out_r <= push_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.job       = job_r;
    sts.job2      = job2_r;
    sts.xb_ok     = (xb_r < ew);
    sts.em_a      = ema_r;
    sts.em_b      = emb_r;
    sts.div_busy  = div_busy;
    sts.stage_vld = stg_vld_r;
    sts.out_free  = !out_valid_r || out_ready;
  end
endmodule
`default_nettype wire

// ===== rtl/wmsk_ctrl.sv =====
// Sequencer: steps one pixel through row, column and result phases.
`default_nettype none
module wmsk_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire wmsk_pkg::wmsk_sts_t sts,
  output wmsk_pkg::wmsk_cmd_t      cmd
);
  import wmsk_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_WV, S_ROW, S_JOB, S_RD, S_COL, S_EMSEL,
    S_MULV, S_LDV, S_DIVV, S_FINV, S_MULW, S_LDW, S_DIVW, S_FINW,
    S_STAGE, S_NEXTJOB, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_WV;
        end
      end
      S_WV: begin
        cmd.wv    = 1'b1;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.row   = 1'b1;
        state_nxt = S_JOB;
      end
      S_JOB: begin
        if (!sts.job)       state_nxt = S_DONE;
        else if (sts.xb_ok) state_nxt = S_RD;
        else                state_nxt = S_NEXTJOB;
      end
      S_RD: state_nxt = S_COL;
      S_COL: begin
        cmd.col   = 1'b1;
        state_nxt = S_EMSEL;
      end
      S_EMSEL: begin
        if (sts.em_a) begin
          cmd.ema_clr = 1'b1;
          state_nxt   = S_MULV;
        end else if (sts.em_b) begin
          cmd.emb   = 1'b1;
          state_nxt = S_MULV;
        end else begin
          state_nxt = S_NEXTJOB;
        end
      end
      S_MULV: begin
        cmd.mul_v = 1'b1;
        state_nxt = S_LDV;
      end
      S_LDV: begin
        cmd.div_v = 1'b1;
        state_nxt = S_DIVV;
      end
      S_DIVV: if (!sts.div_busy) state_nxt = S_FINV;
      S_FINV: begin
        cmd.fin_v = 1'b1;
        state_nxt = S_MULW;
      end
      S_MULW: begin
        cmd.mul_w = 1'b1;
        state_nxt = S_LDW;
      end
      S_LDW: begin
        cmd.div_w = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: if (!sts.div_busy) state_nxt = S_FINW;
      S_FINW: state_nxt = S_STAGE;
      S_STAGE: begin
        if (!sts.stage_vld || sts.out_free) begin
          cmd.stage = 1'b1;
          state_nxt = S_EMSEL;
        end
      end
      S_NEXTJOB: begin
        if (sts.job2) begin
          cmd.job2  = 1'b1;
          state_nxt = S_JOB;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.stage_vld) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.push_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // weight result is captured together with the staging step
    cmd.fin_w = cmd.stage;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  a_stage_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.stage && sts.stage_vld) || cmd.push_last |-> sts.out_free)
    else $error("result pushed while output register is occupied");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_v || cmd.div_w) |-> !sts.div_busy)
    else $error("divider restarted while busy");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.stage_vld && !sts.div_busy)
    else $error("new pixel admitted with work left over");

  a_take_flow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> !in_ready ##1 !in_ready)
    else $error("pixel sequence cut short");
endmodule
`default_nettype wire

// ===== rtl/weighted_map_shrink_2x.sv =====
// A pixel updates the row sums, and the column store too when it closes a column.
// Each result runs the shared divider twice, for the mean and the weight, on a 52-bit dividend.
// One pixel at a time; up to 4 results per pixel.
// The last result of a pixel waits in a staging register; the next pixel is taken
// as soon as it moves to the output register, even before it is read.
// Reset (synchronous, rst_n low): raster position at (0,0), config at defaults; no clearing pass.
`default_nettype none
module weighted_map_shrink_2x #(
  parameter int MAX_IN_WIDTH = wmsk_pkg::MAX_IN_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire wmsk_pkg::wmsk_in_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output wmsk_pkg::wmsk_out_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [wmsk_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [wmsk_pkg::CFG_DW-1:0] cfg_data
);
  import wmsk_pkg::*;

  // Controller issues one command set per cycle; datapath reports back status.
  wmsk_cmd_t cmd;
  wmsk_sts_t sts;

  // Sequencer: take pixel, form weight*value product, update the row
  // partial sums, then for each finished column (at most two per pixel)
  // read the column store, fold in the row sums and emit up to two results.
  wmsk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: column store of MAX_IN_WIDTH/2+1 entries (one read/write port),
  // one shared multiplier and one bit-serial divider used for both the
  // scaled mean and the combined weight of every result transfer.
  wmsk_datapath #(.MAX_IN_WIDTH(MAX_IN_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

// ===== tb/wmsk_checker.sv =====
// Scoreboard for the weighted 2x map shrink: predicts output pixels and checks them.
`timescale 1ns / 100ps
module wmsk_checker
  import wmsk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  wmsk_in_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  wmsk_out_t           out_data,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data,
  output int                  mismatches,
  output int                  pending,
  output int                  results_seen
);

  localparam int MAXW = MAX_IN_WIDTH_DEF;

  // shadow registers
  logic [11:0] geo_iw, geo_ih;
  logic [10:0] geo_ow, geo_oh;
  logic        wt_on;
  logic [15:0] val_scale;

  // column and row accumulators, taps 1,2,1
  longint unsigned col_w [MAXW+2];
  longint unsigned col_s [MAXW+2];
  longint          col_v [MAXW+2];
  longint unsigned row_w, row_s;
  longint          row_v;
  int unsigned     pos_x, pos_y;

  wmsk_out_t expected_pixels[$];
  wmsk_out_t step_pixels[$];

  assign pending = expected_pixels.size();

  function automatic int unsigned in_cols();
    if (geo_iw < 1) return 1;
    if (geo_iw > MAXW) return MAXW;
    return geo_iw;
  endfunction

  function automatic int unsigned in_rows();
    return (geo_ih < 1) ? 1 : geo_ih;
  endfunction

  function automatic int unsigned out_cols();
    int unsigned o, lim;
    o = (geo_ow < 1) ? 1 : geo_ow;
    lim = in_cols() / 2 + 1;
    return (o < lim) ? o : lim;
  endfunction

  function automatic int unsigned out_rows();
    int unsigned o, lim;
    o = (geo_oh < 1) ? 1 : geo_oh;
    lim = in_rows() / 2 + 1;
    return (o < lim) ? o : lim;
  endfunction

  // scale*sv/(s1*256), nearest, ties away from zero, saturated
  function automatic logic signed [15:0] scaled_mean(longint sv, longint unsigned s1);
    longint          sc;
    longint unsigned d, mag, s, a, r, q, rem;
    bit              neg;
    sc = longint'($signed(val_scale));
    d = s1 * 256;
    neg = (sv < 0) != (sc < 0);
    if (sv == 0 || sc == 0 || d == 0) return '0;
    mag = (sv < 0) ? longint'(-sv) : sv;
    s = (sc < 0) ? longint'(-sc) : sc;
    a = mag / d;
    r = mag % d;
    if (a >= (64'd1 << 40)) begin
      q = 64'd1 << 40;
    end else begin
      q = a * s + (r * s) / d;
      rem = (r * s) % d;
      if (2 * rem >= d) q++;
    end
    if (neg) return (q > 32768) ? -16'sd32768 : -$signed(q[15:0]);
    return (q > 32767) ? 16'sd32767 : $signed(q[15:0]);
  endfunction

  function automatic void emit(longint unsigned s1, longint unsigned s2, longint sv, bit fl);
    wmsk_out_t       o;
    longint unsigned num, w, rm;
    o = '0;
    if (s1 != 0 && s2 != 0) begin
      o.out_value = scaled_mean(sv, s1);
      if (wt_on) begin
        num = s1 * s1;
        w = num / s2;
        rm = num % s2;
        if (2 * rm >= s2) w++;
        if (w > 65535) w = 65535;
        o.out_weight = w[15:0];
      end
    end
    o.out_bad = (s1 == 0);
    o.frame_last = fl;
    if (step_pixels.size() < 4) step_pixels.push_back(o);
  endfunction

  // a horizontal 3-tap sum for output column xb is done on input row y
  function automatic void close_column(int unsigned xb, longint unsigned h1,
                                       longint unsigned h2, longint hv, int unsigned y);
    int unsigned ew, eh, yb;
    bit          lastrow;
    ew = out_cols();
    eh = out_rows();
    lastrow = (y == in_rows() - 1);
    if (xb >= ew) return;
    if (y[0] == 1'b0) begin
      yb = y / 2;
      if (y == 0) begin
        col_w[xb] = 2 * h1; col_s[xb] = 4 * h2; col_v[xb] = 2 * hv;
      end else begin
        col_w[xb] += 2 * h1; col_s[xb] += 4 * h2; col_v[xb] += 2 * hv;
      end
      if (lastrow && yb < eh)
        emit(col_w[xb], col_s[xb], col_v[xb], yb == eh - 1 && xb == ew - 1);
    end else begin
      yb = (y - 1) / 2;
      if (yb < eh)
        emit(col_w[xb] + h1, col_s[xb] + h2, col_v[xb] + hv,
             yb == eh - 1 && xb == ew - 1);
      col_w[xb] = h1; col_s[xb] = h2; col_v[xb] = hv;
      if (lastrow && yb + 1 < eh)
        emit(h1, h2, hv, yb + 1 == eh - 1 && xb == ew - 1);
    end
  endfunction

  function automatic void predict_pixel(wmsk_in_t px);
    int unsigned     nx, ny, x, y;
    longint unsigned w1;
    longint          v, wv;
    nx = in_cols();
    ny = in_rows();
    x = pos_x;
    y = pos_y;
    if (x >= nx) begin x = 0; y++; end
    if (y >= ny) y = 0;
    v = longint'(px.pixel_value);
    w1 = wt_on ? px.pixel_weight : ONE_WEIGHT;
    wv = longint'(w1) * v;
    step_pixels.delete();
    if (x[0] == 1'b0) begin
      if (x == 0) begin
        row_w = 2 * w1; row_s = 4 * w1; row_v = 2 * wv;
      end else begin
        row_w += 2 * w1; row_s += 4 * w1; row_v += 2 * wv;
      end
      if (x == nx - 1) close_column(x / 2, row_w, row_s, row_v, y);
    end else begin
      row_w += w1; row_s += w1; row_v += wv;
      close_column((x - 1) / 2, row_w, row_s, row_v, y);
      row_w = w1; row_s = w1; row_v = wv;
      if (x == nx - 1) close_column((x + 1) / 2, row_w, row_s, row_v, y);
    end
    x++;
    if (x >= nx) begin
      x = 0;
      y++;
      if (y >= ny) y = 0;
    end
    pos_x = x;
    pos_y = y;
    if (step_pixels.size() > 0) step_pixels[step_pixels.size()-1].run_last = 1'b1;
    foreach (step_pixels[i]) expected_pixels.push_back(step_pixels[i]);
  endfunction

  always @(posedge clk) begin
    wmsk_out_t want;
    if (!rst_n) begin
      geo_iw <= 12'd2048; geo_ih <= 12'd2048;
      geo_ow <= 11'd1024; geo_oh <= 11'd1024;
      wt_on <= 1'b1; val_scale <= 16'd256;
      row_w = 0; row_s = 0; row_v = 0;
      pos_x = 0; pos_y = 0;
      expected_pixels.delete();
      mismatches <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IN_WIDTH:   geo_iw <= cfg_data[11:0];
          CFG_IN_HEIGHT:  geo_ih <= cfg_data[11:0];
          CFG_OUT_WIDTH:  geo_ow <= cfg_data[10:0];
          CFG_OUT_HEIGHT: geo_oh <= cfg_data[10:0];
          CFG_WEIGHT_PR:  wt_on <= cfg_data[0];
          CFG_SCALE:      val_scale <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_pixel(in_data);
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_pixels.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected output pixel %p", $realtime, out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (want.out_value !== out_data.out_value ||
              want.out_weight !== out_data.out_weight ||
              want.out_bad !== out_data.out_bad ||
              want.run_last !== out_data.run_last ||
              want.frame_last !== out_data.frame_last) begin
            if (mismatches < 10)
              $display("[%0t] pixel %0d: exp val %0d wt %0d bad %b rl %b fl %b, got val %0d wt %0d bad %b rl %b fl %b",
                       $realtime, results_seen, want.out_value, want.out_weight,
                       want.out_bad, want.run_last, want.frame_last,
                       out_data.out_value, out_data.out_weight, out_data.out_bad,
                       out_data.run_last, out_data.frame_last);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_weighted_map_shrink_2x.sv =====
// Top-level testbench for the weighted 2x map shrink: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_weighted_map_shrink_2x;
  import wmsk_pkg::*;

  // no-transfer cycles tolerated; a pixel with four windows runs the divider eight times
  // plus receiver stalls, so this leaves a wide margin
  localparam int IDLE_LIMIT = 20000;
  // settle time after the last expected pixel: covers a pixel with no output
  localparam int SETTLE = 30;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  wmsk_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  wmsk_out_t         out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  int mismatches, pending, results_seen;
  int pixels_sent, frames_sent, burst_left;
  int idle_cycles;
  int stall_mode, stall_left;

  weighted_map_shrink_2x dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  wmsk_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .pending, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: switches between always-ready, coin-flip and long-stall modes
  // at random intervals so stalls land on every phase of the divider.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d pixels still owed",
                 IDLE_LIMIT, pending);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // One input transfer. Valid stays up into the next pixel unless the
  // burst ends, in which case it drops for a random gap.
  task automatic send_pixel(input logic [15:0] value, input logic [15:0] weight);
    in_data <= '{pixel_value: value, pixel_weight: weight};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  // Wait until every predicted pixel is out and the pipe has drained, so
  // the next register write lands on an idle block.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all six registers back to back; write enable drops only at the end.
  task automatic program_regs(input int iw, input int ih, input int ow, input int oh,
                              input int wp, input int sc);
    logic [CFG_DW-1:0] vals [6];
    logic [CFG_IW-1:0] idx [6];
    idx = '{CFG_IN_WIDTH, CFG_IN_HEIGHT, CFG_OUT_WIDTH, CFG_OUT_HEIGHT,
            CFG_WEIGHT_PR, CFG_SCALE};
    vals = '{iw[15:0], ih[15:0], ow[15:0], oh[15:0], wp[15:0], sc[15:0]};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random pixel: extremes and zero weight show up often on purpose.
  task automatic send_random_pixel();
    logic [15:0] v, w;
    case ($urandom_range(0, 7))
      0: v = 16'h7fff;
      1: v = 16'h8000;
      default: v = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: w = 16'h0000;
      1: w = 16'hffff;
      2: w = ONE_WEIGHT;
      default: w = 16'($urandom);
    endcase
    send_pixel(v, w);
  endtask

  task automatic random_frame(input int nx, input int ny);
    for (int i = 0; i < nx * ny; i++) send_random_pixel();
    frames_sent++;
    drain();
  endtask

  initial begin
    int iw, ih, ow, oh, sc;
    burst_left = $urandom_range(1, 20);
    stall_left = 0;
    stall_mode = 0;
    idle_cycles = 0;
    pixels_sent = 0;
    frames_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 4x4 map with output width at its limit, value and weight extremes
    program_regs(4, 4, 3, 3, 1, 256);
    for (int i = 0; i < 16; i++)
      send_pixel((i % 3 == 0) ? 16'h7fff : (i % 3 == 1) ? 16'h8000 : 16'h0000,
                 (i < 4) ? 16'hffff : (i % 5 == 0) ? 16'h0000 : 16'h0001);
    frames_sent++;
    drain();
    // single pixel of zero weight: empty window, bad flag
    program_regs(1, 1, 1, 1, 1, 32767);
    send_pixel(16'h1234, 16'h0000);
    frames_sent++;
    drain();
    // zero geometry clamps to 1x1; weights absent; most negative scale
    program_regs(0, 0, 0, 0, 0, -32768);
    send_pixel(16'h8000, 16'hffff);
    frames_sent++;
    drain();
    // zero scale on a 3x3 map
    program_regs(3, 3, 2, 2, 1, 0);
    for (int i = 0; i < 9; i++) send_pixel(16'(16'h7fff - i), 16'h0100 << (i % 8));
    frames_sent++;
    drain();

    // Random small maps with random settings, sized to end near 130 pixels
    while (pixels_sent < 120) begin
      iw = $urandom_range(1, 9);
      ih = $urandom_range(1, 9);
      if (iw * ih > 130 - pixels_sent) ih = (130 - pixels_sent) / iw;
      if (ih < 1) ih = 1;
      ow = $urandom_range(0, iw / 2 + 2);
      oh = $urandom_range(0, ih / 2 + 2);
      case ($urandom_range(0, 4))
        0: sc = 32767;
        1: sc = -32768;
        2: sc = 256;
        default: sc = $urandom;
      endcase
      program_regs(iw, ih, ow, oh, $urandom_range(0, 1), sc);
      random_frame(iw, ih);
    end

    $display("covered %0d frames, %0d pixels in, %0d output pixels checked",
             frames_sent, pixels_sent, results_seen);
    $display("geometry from clamped zero sizes up to 9x9, weights on and off, scale extremes");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
